@@ src/fdsc_pkg.sv @@
// Shared types and status codes for the frame deframer with sum checksum.
package fdsc_pkg;

   typedef enum logic [1:0] {
      ST_CONTINUE = 2'd0,
      ST_GOOD     = 2'd1,
      ST_ERROR    = 2'd2
   } status_type;

   localparam int unsigned LEN_BYTES = 4;

   typedef struct packed {
      logic [7:0]  rx_byte;
      logic [32:0] byte_index;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [31:0] payload_offset;
   } rsp_type;

   // Input register contents handed to the parser.
   typedef struct packed {
      logic    valid;
      req_type data;
   } stage_type;

endpackage

@@ src/frame_deframer_sum_checksum_unit.sv @@
// Top level of the frame deframer with sum checksum.
//
//   channel  direction  handshake              contents
//   req      in         req_valid / req_ready  req_type: rx_byte, byte_index
//   rsp      out        rsp_valid / rsp_ready  rsp_type: status, payload fields
//   csr      in         csr_valid / csr_ready  magic_word write data
//
// One transaction per cycle sustained while rsp_ready is high; a taken request is loaded into the
// input register, then moves into the result register, from which it is presented on rsp.
// Length and sum state update when a transaction moves into the result register.
// A stalled rsp_ready backs up through both registers to req_ready in the same cycle.
// Synchronous reset clears valids, state and magic_word; csr_ready is always high.
module frame_deframer_sum_checksum_unit
   import fdsc_pkg::*;
#(
   parameter int unsigned MAGIC_LEN = 4
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic [31:0] magic_word_ff, magic_word_in;
   stage_type   stage;
   logic        stage_take;

   assign csr_ready     = 1'b1;
   assign magic_word_in = (csr_valid && csr_ready) ? csr_data : magic_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff <= 32'd0;
      end else begin
         magic_word_ff <= magic_word_in;
      end
   end

   fdsc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .stage_take  (stage_take),
      .stage       (stage)
   );

   fdsc_parse #(
      .MAGIC_LEN (MAGIC_LEN)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .magic_word  (magic_word_ff),
      .stage       (stage),
      .stage_take  (stage_take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ src/fdsc_in_stage.sv @@
// Input register: captures one request transaction per cycle while req_ready is high.
module fdsc_in_stage
   import fdsc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_payload,
   input  logic      stage_take,
   output stage_type stage
);

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;

   assign req_ready = !valid_ff || stage_take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_ready) begin
         valid_in = req_valid;
         data_in  = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;

endmodule

@@ src/fdsc_parse.sv @@
// Frame parser: length and sum state, field decode and the result register.
module fdsc_parse
   import fdsc_pkg::*;
#(
   parameter int unsigned MAGIC_LEN = 4
)(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] magic_word,
   input  stage_type   stage,
   output logic        stage_take,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload
);

   localparam logic [32:0] LEN_START = 33'(MAGIC_LEN);
   localparam logic [32:0] PAY_START = 33'(MAGIC_LEN + LEN_BYTES);

   logic [31:0] frame_length_ff, frame_length_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [32:0] pos;
   logic [7:0]  b;
   logic [31:0] len_base;
   logic [7:0]  sum_base;
   logic [32:0] crc_pos;
   logic [7:0]  want;
   logic [1:0]  lane;
   logic [32:0] offset;
   rsp_type     result;
   logic [31:0] length_next;
   logic [7:0]  sum_next;

   assign stage_take = stage.valid && (!rsp_valid_ff || rsp_ready);

   assign pos      = stage.data.byte_index;
   assign b        = stage.data.rx_byte;
   // Start of frame clears length and sum before the byte is looked at.
   assign len_base = (pos == 33'd0) ? 32'd0 : frame_length_ff;
   assign sum_base = (pos == 33'd0) ? 8'd0 : running_sum_ff;
   assign crc_pos  = PAY_START + {1'b0, len_base};
   assign want     = magic_word[{pos[1:0], 3'b000} +: 8];
   assign lane     = pos[1:0] - LEN_START[1:0];
   assign offset   = pos - PAY_START;

   always_comb begin
      result.status         = ST_ERROR;
      result.payload_valid  = 1'b0;
      result.payload_byte   = 8'd0;
      result.payload_offset = 32'd0;
      length_next           = len_base;
      sum_next              = sum_base;
      priority if (pos < LEN_START) begin
         result.status = (b == want) ? ST_CONTINUE : ST_ERROR;
      end else if (pos < PAY_START) begin
         length_next   = len_base | (32'(b) << {lane, 3'b000});
         result.status = ST_CONTINUE;
      end else if (pos < crc_pos) begin
         sum_next              = sum_base + b;
         result.status         = ST_CONTINUE;
         result.payload_valid  = 1'b1;
         result.payload_byte   = b;
         result.payload_offset = offset[31:0];
      end else if (pos == crc_pos) begin
         result.status = (b == sum_base) ? ST_GOOD : ST_ERROR;
      end else begin
         result.status = ST_ERROR;
      end
   end

   always_comb begin
      frame_length_in = frame_length_ff;
      running_sum_in  = running_sum_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      if (stage_take) begin
         frame_length_in = length_next;
         running_sum_in  = sum_next;
         rsp_in          = result;
         rsp_valid_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= 32'd0;
         running_sum_ff  <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_length_ff <= frame_length_in;
         running_sum_ff  <= running_sum_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_take_loads_result: assert property (@(posedge clock) disable iff (reset)
      stage_take |=> rsp_valid_ff)
      else $error("taken transaction did not reach the result register");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (stage_take && pos == 33'd0) |=> (frame_length_ff == 32'd0 && running_sum_ff == 8'd0))
      else $error("start of frame did not clear length and sum");

   a_payload_continue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.payload_valid) |-> rsp_ff.status == ST_CONTINUE)
      else $error("payload byte reported with final status");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.payload_valid)
         |-> (rsp_ff.payload_byte == 8'd0 && rsp_ff.payload_offset == 32'd0))
      else $error("non-payload result carries payload data");

endmodule
